### sv/keyed_accumulate_table_fifo_evict_assert.svh
// Assertion macros used by the keyed accumulate table controller.
`ifndef KEYED_ACCUMULATE_TABLE_FIFO_EVICT_ASSERT_SVH
`define KEYED_ACCUMULATE_TABLE_FIFO_EVICT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define KATFE_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define KATFE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/katfe_pkg.sv
// Package with the sizes, codes, scale function and control struct of the table.
package katfe_pkg;

  // Table geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int ID_W    = 24;
  localparam int SHARE_W = 16;
  localparam int TOTAL_W = 24;
  localparam int SCALE_W = 7;
  localparam int ENTRY_W = KIND_W + ID_W + TOTAL_W;

  // Packed input beat: command, kind, id, share from the low bits up.
  localparam int IN_W = 1 + KIND_W + ID_W + SHARE_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Command codes.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Key kinds; every other code is not a key.
  localparam logic [KIND_W-1:0] KIND_CREATURE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLAYER   = 2'd2;

  // Scale thresholds in hundredths and the matching percentages.
  localparam logic [TOTAL_W-1:0] THR_1 = 24'd201;
  localparam logic [TOTAL_W-1:0] THR_2 = 24'd301;
  localparam logic [TOTAL_W-1:0] THR_3 = 24'd501;
  localparam logic [TOTAL_W-1:0] THR_4 = 24'd701;
  localparam logic [TOTAL_W-1:0] THR_5 = 24'd1001;

  localparam logic [SCALE_W-1:0] SCALE_0 = 7'd100;
  localparam logic [SCALE_W-1:0] SCALE_1 = 7'd95;
  localparam logic [SCALE_W-1:0] SCALE_2 = 7'd85;
  localparam logic [SCALE_W-1:0] SCALE_3 = 7'd65;
  localparam logic [SCALE_W-1:0] SCALE_4 = 7'd45;
  localparam logic [SCALE_W-1:0] SCALE_5 = 7'd30;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;     // capture the input beat
    logic             rd_en;    // issue a table read
    logic [IDX_W-1:0] rd_addr;  // entry being read
    logic             cmp;      // read data of cmp_idx is on the bus
    logic [IDX_W-1:0] cmp_idx;  // entry under compare
    logic             commit;   // update the table and load the result
  } ctl_cmd_t;

  // Reward scale percentage for a total in hundredths.
  function automatic logic [SCALE_W-1:0] scale_of(input logic [TOTAL_W-1:0] t);
    logic [SCALE_W-1:0] s;
    if (t < THR_1) s = SCALE_0;
    else if (t < THR_2) s = SCALE_1;
    else if (t < THR_3) s = SCALE_2;
    else if (t < THR_4) s = SCALE_3;
    else if (t < THR_5) s = SCALE_4;
    else s = SCALE_5;
    return s;
  endfunction

endpackage

### sv/keyed_accumulate_table_fifo_evict.sv
// Top level of the keyed accumulate table with ring-order replacement.
// An accepted beat scans the table RAM one entry a cycle through the registered read port
// and stops at the first hit or after the last entry; the result beat is then loaded into
// the output register, and the next beat is taken in the cycle after that commit.
// A waiting result stalls only the next commit.
// Synchronous reset marks every entry empty at once and resets the replacement pointer.
module keyed_accumulate_table_fifo_evict (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // victim_id [23:0], kill_share [39:24]
  input  logic [2:0]  s_tuser,   // command [0], victim_kind [2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // total_amount [23:0], scale_percent [30:24], zero [31]
  output logic        m_tuser    // key_found [0]
);
  import katfe_pkg::*;

  ctl_cmd_t           ctl;
  logic               match;
  logic [TOTAL_W-1:0] total_amount;
  logic               key_found;
  logic [SCALE_W-1:0] scale_percent;
  logic [IN_W-1:0]    in_bits;

  // Pack the beat as command, kind, id, share from the low bits up.
  assign in_bits = {s_tdata[39:24], s_tdata[23:0], s_tuser[2:1], s_tuser[0]};

  katfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .match     (match),
    .ctl       (ctl)
  );

  katfe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .in_bits       (in_bits),
    .match         (match),
    .total_amount  (total_amount),
    .key_found     (key_found),
    .scale_percent (scale_percent)
  );

  assign m_tdata = {1'b0, scale_percent, total_amount};
  assign m_tuser = key_found;

endmodule

### sv/katfe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module katfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/katfe_datapath.sv
// Datapath: input capture, entry compare, table storage, update and result register.
module katfe_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  katfe_pkg::ctl_cmd_t                ctl,
  input  logic [katfe_pkg::IN_W-1:0]         in_bits,   // command, kind, id, share
  output logic                               match,
  output logic [katfe_pkg::TOTAL_W-1:0]      total_amount,
  output logic                               key_found,
  output logic [katfe_pkg::SCALE_W-1:0]      scale_percent
);
  import katfe_pkg::*;

  // Captured input beat.
  logic               cmd_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ID_W-1:0]    key_r;
  logic [SHARE_W-1:0] share_r;

  // Table state kept in flip-flops.
  logic [DEPTH-1:0]   valid;
  logic [IDX_W-1:0]   oldest;

  // Hit tracking for the current item.
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx;
  logic [TOTAL_W-1:0] hit_total;

  // Memory ports.
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [KIND_W-1:0]  rd_kind;
  logic [ID_W-1:0]    rd_key;
  logic [TOTAL_W-1:0] rd_total;

  logic               kind_ok;
  logic               is_record;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_sum;
  logic [TOTAL_W-1:0] res_total;

  katfe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (rdata)
  );

  assign {rd_kind, rd_key, rd_total} = rdata;

  // An empty or invalid kind never matches.
  assign kind_ok   = (kind_r == KIND_CREATURE) || (kind_r == KIND_PLAYER);
  assign is_record = (cmd_r == CMD_RECORD);
  assign match     = ctl.cmp && valid[ctl.cmp_idx] && kind_ok &&
                     (rd_kind == kind_r) && (rd_key == key_r);

  // Saturating accumulate on a hit.
  assign sum     = {1'b0, hit_total} + {{(TOTAL_W + 1 - SHARE_W){1'b0}}, share_r};
  assign sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // Total after the operation.
  always_comb begin
    if (hit_r) begin
      res_total = is_record ? sat_sum : hit_total;
    end else if (is_record && kind_ok) begin
      res_total = {{(TOTAL_W - SHARE_W){1'b0}}, share_r};
    end else begin
      res_total = '0;
    end
  end

  // Table write: update the hit entry or replace the oldest one.
  assign we    = ctl.commit && is_record && kind_ok;
  assign waddr = hit_r ? hit_idx : oldest;
  assign wdata = {kind_r, key_r, res_total};

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      oldest <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (ctl.load) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
      if (we && !hit_r) begin
        valid[oldest] <= 1'b1;
        oldest <= (oldest == IDX_W'(DEPTH - 1)) ? '0 : oldest + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      {share_r, key_r, kind_r, cmd_r} <= in_bits;
    end
    if (match) begin
      hit_idx   <= ctl.cmp_idx;
      hit_total <= rd_total;
    end
    if (ctl.commit) begin
      total_amount  <= res_total;
      key_found     <= hit_r;
      scale_percent <= scale_of(res_total);
    end
  end

endmodule

### sv/katfe_ctrl.sv
// Controller: sequences capture, table scan, commit and the output handshake.
module katfe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                match,
  output katfe_pkg::ctl_cmd_t ctl
);
  import katfe_pkg::*;

  `include "keyed_accumulate_table_fifo_evict_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  state_t           state;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_pend;
  logic             accept;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Commands to the datapath.
  always_comb begin
    ctl.load    = accept;
    ctl.rd_en   = (state == S_SCAN);
    ctl.rd_addr = rd_idx;
    ctl.cmp     = cmp_pend;
    ctl.cmp_idx = cmp_idx;
    ctl.commit  = (state == S_FINISH) && out_free;
  end

  // State machine with the scan counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      cmp_idx   <= '0;
      cmp_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A commit loads a new result beat; otherwise an accepted beat empties the output.
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            rd_idx   <= '0;
            cmp_pend <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cmp_pend && (match || cmp_idx == LAST)) begin
            state    <= S_FINISH;
            cmp_pend <= 1'b0;
          end else begin
            cmp_pend <= 1'b1;
            cmp_idx  <= rd_idx;
            rd_idx   <= (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KATFE_ASSERT_IMPL(a_commit_free, ctl.commit, !out_valid || out_ready, "commit with output busy")
  `KATFE_ASSERT_NEXT(a_commit_valid, ctl.commit, out_valid, "commit did not raise valid")
  `KATFE_ASSERT_NEXT(a_one_item, accept, !in_ready, "second item taken during scan")
  `KATFE_ASSERT_IMPL(a_cmp_in_scan, ctl.cmp, state == S_SCAN, "compare outside the scan")

endmodule

### tb/testbench.sv
// Self-checking testbench for the keyed accumulate table with ring-order replacement.
module testbench;
  import katfe_pkg::*;

  // Kind codes that are not keys; the block must leave its table alone for them.
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  localparam int POOL_SIZE   = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         s_tdata = '0;   // victim_id [23:0], kill_share [39:24]
  logic [2:0]          s_tuser = '0;   // command [0], victim_kind [2:1]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;        // total_amount [23:0], scale_percent [30:24], zero [31]
  logic                m_tuser;        // key_found [0]

  int                  cycle_count = 0;
  bit                  no_idle = 1'b0;
  logic [ID_W-1:0]     id_pool [POOL_SIZE];

  // One expected result beat.
  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               found;
    logic [SCALE_W-1:0] scale;
  } payout_t;

  // Mirror of the table plus the queue of results still owed by the block.
  class share_ledger;
    logic [KIND_W-1:0]  slot_kind  [DEPTH];
    logic [ID_W-1:0]    slot_id    [DEPTH];
    logic [TOTAL_W-1:0] slot_total [DEPTH];
    int                 ring_ptr;
    payout_t            owed [$];
    int                 mismatches;
    int                 results_seen;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_kind[i]  = KIND_NONE;
        slot_id[i]    = '0;
        slot_total[i] = '0;
      end
      ring_ptr     = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Reward scale in percent from a total in hundredths.
    function logic [SCALE_W-1:0] reward_pct(logic [TOTAL_W-1:0] t);
      if (t <= 200) return 7'd100;
      if (t <= 300) return 7'd95;
      if (t <= 500) return 7'd85;
      if (t <= 700) return 7'd65;
      if (t <= 1000) return 7'd45;
      return 7'd30;
    endfunction

    // Apply an accepted command to the mirror and queue the result it causes.
    function void note_beat(logic cmd, logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                            logic [SHARE_W-1:0] share);
      payout_t          res;
      int               hit;
      logic [TOTAL_W:0] sum;
      res.total = '0;
      res.found = 1'b0;
      hit = -1;
      if (kind == KIND_CREATURE || kind == KIND_PLAYER) begin
        for (int i = 0; i < DEPTH; i++)
          if (hit < 0 && slot_kind[i] == kind && slot_id[i] == id) hit = i;
        if (hit >= 0) begin
          res.found = 1'b1;
          if (cmd == CMD_RECORD) begin
            sum = {1'b0, slot_total[hit]} + (TOTAL_W + 1)'(share);
            slot_total[hit] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
          end
          res.total = slot_total[hit];
        end else if (cmd == CMD_RECORD) begin
          // A new key replaces the oldest entry in ring order.
          slot_kind[ring_ptr]  = kind;
          slot_id[ring_ptr]    = id;
          slot_total[ring_ptr] = TOTAL_W'(share);
          ring_ptr  = (ring_ptr + 1) % DEPTH;
          res.total = TOTAL_W'(share);
        end
      end
      res.scale = reward_pct(res.total);
      owed.push_back(res);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    // Compare a result beat with the oldest outstanding expectation.
    task check_result(logic [TOTAL_W-1:0] total, logic found, logic [SCALE_W-1:0] scale,
                      logic pad);
      payout_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing outstanding", total, 0);
        return;
      end
      want = owed.pop_front();
      if (total !== want.total) report_mismatch("total_amount", total, want.total);
      if (found !== want.found) report_mismatch("key_found", found, want.found);
      if (scale !== want.scale) report_mismatch("scale_percent", scale, want.scale);
      if (pad !== 1'b0) report_mismatch("padding bit", pad, 0);
      results_seen++;
    endtask
  endclass

  share_ledger ledger = new();

  keyed_accumulate_table_fifo_evict u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  // Result side: take beats, check them, and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        ledger.check_result(m_tdata[23:0], m_tuser, m_tdata[30:24], m_tdata[31]);
      m_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Present one command beat, with an optional idle gap first, and wait for acceptance.
  task automatic send_beat(logic cmd, logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                           logic [SHARE_W-1:0] share);
    if (!no_idle && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {share, id};
    s_tuser  <= {kind, cmd};
    do @(posedge clk); while (!s_tready);
    ledger.note_beat(cmd, kind, id, share);
  endtask

  // Hold off the sender until every outstanding result has been delivered.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  // Mixed traffic over a small key pool so that hits, misses and evictions all occur.
  task automatic random_traffic(int count, int quiet_from, int quiet_to);
    logic               cmd;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    id;
    logic [SHARE_W-1:0] share;
    logic [31:0]        raw;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= quiet_from && n < quiet_to);
      if (n % 64 == 63) begin
        raw = $urandom;
        id_pool[$urandom_range(POOL_SIZE - 1)] = raw[ID_W-1:0];
      end
      cmd = ($urandom_range(99) < 60) ? CMD_RECORD : CMD_QUERY;
      raw = $urandom;
      if ($urandom_range(99) < 8) begin
        kind = $urandom_range(1) ? KIND_NONE : KIND_RESERVED;
        id   = raw[ID_W-1:0];
      end else begin
        kind = $urandom_range(1) ? KIND_CREATURE : KIND_PLAYER;
        id   = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                         : raw[ID_W-1:0];
      end
      raw   = $urandom;
      share = $urandom_range(1) ? SHARE_W'($urandom_range(400)) : raw[SHARE_W-1:0];
      send_beat(cmd, kind, id, share);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [ID_W-1:0]    hot_id;
    logic [31:0]        raw;
    logic [SHARE_W-1:0] thr_share [10];

    thr_share = '{16'd200, 16'd201, 16'd300, 16'd301, 16'd500,
                  16'd501, 16'd700, 16'd701, 16'd1000, 16'd1001};
    for (int i = 0; i < POOL_SIZE; i++) begin
      raw = $urandom;
      id_pool[i] = raw[ID_W-1:0];
    end
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty table, and kinds that are not keys.
    send_beat(CMD_QUERY,  KIND_CREATURE, '0, '0);
    send_beat(CMD_RECORD, KIND_NONE,     '0, 16'd500);
    send_beat(CMD_QUERY,  KIND_NONE,     '0, '0);
    send_beat(CMD_RECORD, KIND_RESERVED, '1, '1);
    send_beat(CMD_QUERY,  KIND_RESERVED, '1, '1);
    // Extremes of id and share, hits, and the same id under the other kind.
    send_beat(CMD_RECORD, KIND_CREATURE, '0, '0);
    send_beat(CMD_RECORD, KIND_CREATURE, '0, '1);
    send_beat(CMD_QUERY,  KIND_CREATURE, '0, '1);
    send_beat(CMD_QUERY,  KIND_PLAYER,   '0, '0);
    send_beat(CMD_RECORD, KIND_PLAYER,   '1, '1);
    send_beat(CMD_QUERY,  KIND_PLAYER,   '1, '0);
    // Totals on both sides of each scale threshold.
    for (int i = 0; i < 10; i++)
      send_beat(CMD_RECORD, KIND_PLAYER, ID_W'(i + 1), thr_share[i]);
    send_beat(CMD_RECORD, KIND_CREATURE, '0, 16'd1);
    // Wrap the replacement ring so the first key is evicted.
    for (int i = 0; i < 5; i++)
      send_beat(CMD_RECORD, KIND_CREATURE, ID_W'(100 + i), 16'd7);
    send_beat(CMD_QUERY, KIND_CREATURE, '0, '0);
    drain_results();

    random_traffic(500, 200, 400);
    drain_results();

    // Hammer one key with large shares until its total saturates.
    raw = $urandom;
    hot_id = raw[ID_W-1:0];
    for (int n = 0; n < 300; n++) begin
      if ($urandom_range(99) < 10)
        send_beat(CMD_QUERY, KIND_CREATURE, hot_id, '0);
      else
        send_beat(CMD_RECORD, KIND_CREATURE, hot_id, SHARE_W'($urandom_range(60000, 65535)));
    end

    random_traffic(625, 300, 360);
    s_tvalid <= 1'b0;

    do @(posedge clk); while (ledger.pending() != 0);
    repeat (DEPTH + 8) @(posedge clk);
    if (ledger.pending() != 0)
      ledger.report_mismatch("results never delivered", ledger.pending(), 0);
    if (ledger.mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
